/* rtl/eeid_pkg.sv */
// ----------------------------------------------------------------------------
// eeid_pkg
// Shared widths, register indexes, beat types and helpers for the
// edge event interval debouncer.
// ----------------------------------------------------------------------------
package eeid_pkg;

    // Default geometry
    localparam int LINES_DEF   = 64;
    localparam int HISTORY_DEF = 4;

    // Field widths
    localparam int LINE_W      = 6;
    localparam int STAMP_W     = 48;
    localparam int MIN_GAP_W   = 16;
    localparam int RATIO_W     = 8;
    localparam int DELTA_W     = 31;
    localparam int PROD_W      = STAMP_W + RATIO_W;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO   = 1'd1;

    localparam logic [MIN_GAP_W-1:0] MIN_GAP_RESET = 16'd0;
    localparam logic [RATIO_W-1:0]   RATIO_RESET   = 8'd2;

    localparam logic [DELTA_W-1:0] DELTA_MAX   = 31'h7FFF_FFFF;
    localparam logic [DELTA_W-1:0] DELTA_RANGE = 31'd1;

    // What the decision stage has to do with a beat
    typedef enum logic [1:0] {
        KIND_RANGE,   // line number beyond the table
        KIND_QUIET,   // dropped or history not yet full
        KIND_FIRST,   // history just became full
        KIND_TEST     // ratio test against the largest gap
    } t_kind;

    // Beat handed from the history stage to the decision stages
    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic [LINE_W-1:0]  line;
        logic [STAMP_W-1:0] ts;
    } t_beat;

    // Saturate an interval to the output range
    function automatic logic [DELTA_W-1:0] clamp_delta(input logic [STAMP_W-1:0] v);
        return (v[STAMP_W-1:DELTA_W] != '0) ? DELTA_MAX : v[DELTA_W-1:0];
    endfunction

endpackage

/* rtl/eeid_ram.sv */
// ----------------------------------------------------------------------------
// eeid_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data held while the read enable is low.
// ----------------------------------------------------------------------------
module eeid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/eeid_hist.sv */
// ----------------------------------------------------------------------------
// eeid_hist
// History stage: reads the per-line timestamp history and fill count,
// applies the minimum-gap filter, shifts the new stamp in, writes the entry
// back and hands on the gaps of the updated history.
// ----------------------------------------------------------------------------
module eeid_hist #(
    parameter int LINES   = eeid_pkg::LINES_DEF,
    parameter int HISTORY = eeid_pkg::HISTORY_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic [eeid_pkg::LINE_W-1:0]             i_line,
    input  logic [eeid_pkg::STAMP_W-1:0]            i_ts,
    input  logic [eeid_pkg::MIN_GAP_W-1:0]          i_min_gap,
    output eeid_pkg::t_beat                         o_beat,
    output logic [(HISTORY-1)*eeid_pkg::STAMP_W-1:0] o_gaps
);

    localparam int SW = eeid_pkg::STAMP_W;
    localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int FW = $clog2(HISTORY + 2);
    localparam int HW = HISTORY * SW;
    localparam int EW = HW + FW;
    localparam int GN = HISTORY - 1;

    // Stage 1 registers
    logic                         r_s1_valid;
    logic                         r_s1_in_range;
    logic [eeid_pkg::LINE_W-1:0]  r_s1_line;
    logic [SW-1:0]                r_s1_ts;

    // Bypass of the entry written at the previous edge
    logic                         r_fw_valid;
    logic [LW-1:0]                r_fw_addr;
    logic [EW-1:0]                r_fw_data;

    // Written flags: an entry never written reads as zero
    logic [LINES-1:0]             r_vld;

    logic                         in_range;
    logic [LW-1:0]                rd_addr;
    logic [LW-1:0]                s1_addr;
    logic [EW-1:0]                rd_data;
    logic [EW-1:0]                ent;
    logic [SW-1:0]                h  [HISTORY];
    logic [SW-1:0]                nh [HISTORY];
    logic [FW-1:0]                fill;
    logic [FW-1:0]                n_fill;
    logic [SW-1:0]                gap_new;
    logic                         drop;
    logic                         wr_en;
    logic [EW-1:0]                wr_data;

    assign in_range = {3'b000, i_line} < 9'(LINES);
    assign rd_addr  = LW'(i_line);
    assign s1_addr  = LW'(r_s1_line);

    eeid_ram #(
        .WIDTH (EW),
        .DEPTH (LINES)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (s1_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Select the current entry: bypass, stored, or never written
    always_comb begin
        if (r_fw_valid && (r_fw_addr == s1_addr)) begin
            ent = r_fw_data;
        end else if (r_s1_in_range && r_vld[s1_addr]) begin
            ent = rd_data;
        end else begin
            ent = '0;
        end
        for (int i = 0; i < HISTORY; i++) begin
            h[i] = ent[i*SW +: SW];
        end
        fill = ent[EW-1 -: FW];
    end

    // Filter, shift and count
    always_comb begin
        gap_new = r_s1_ts - h[0];
        drop    = (i_min_gap != '0) && (gap_new < SW'(i_min_gap));
        nh[0]   = r_s1_ts;
        for (int i = 1; i < HISTORY; i++) begin
            nh[i] = h[i-1];
        end
        n_fill = (fill < FW'(HISTORY + 1)) ? fill + 1'b1 : fill;
        for (int i = 0; i < HISTORY; i++) begin
            wr_data[i*SW +: SW] = nh[i];
        end
        wr_data[EW-1 -: FW] = n_fill;
        for (int i = 0; i < GN; i++) begin
            o_gaps[i*SW +: SW] = nh[i] - nh[i+1];
        end
    end

    assign wr_en = i_en && r_s1_valid && r_s1_in_range && !drop;

    // Classify the beat for the decision stages
    always_comb begin
        o_beat.valid = r_s1_valid;
        o_beat.line  = r_s1_line;
        o_beat.ts    = r_s1_ts;
        if (!r_s1_in_range) begin
            o_beat.kind = eeid_pkg::KIND_RANGE;
        end else if (drop || (n_fill < FW'(HISTORY))) begin
            o_beat.kind = eeid_pkg::KIND_QUIET;
        end else if (n_fill == FW'(HISTORY)) begin
            o_beat.kind = eeid_pkg::KIND_FIRST;
        end else begin
            o_beat.kind = eeid_pkg::KIND_TEST;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fw_valid <= 1'b0;
            r_vld      <= '0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_fw_valid <= wr_en;
            if (wr_en) begin
                r_vld[s1_addr] <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_in_range <= in_range;
            r_s1_line     <= i_line;
            r_s1_ts       <= i_ts;
            r_fw_addr     <= s1_addr;
            r_fw_data     <= wr_data;
        end
    end

endmodule

/* rtl/eeid_decide.sv */
// ----------------------------------------------------------------------------
// eeid_decide
// Decision stages: largest history gap and weighted newest gap, then the
// forward test against the per-line last forwarded stamp, which is read,
// updated and written back here. Ends in the output register.
// ----------------------------------------------------------------------------
module eeid_decide #(
    parameter int LINES   = eeid_pkg::LINES_DEF,
    parameter int HISTORY = eeid_pkg::HISTORY_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  eeid_pkg::t_beat                         i_beat,
    input  logic [(HISTORY-1)*eeid_pkg::STAMP_W-1:0] i_gaps,
    input  logic [eeid_pkg::RATIO_W-1:0]            i_ratio,
    output logic                                    o_valid,
    output logic [eeid_pkg::DELTA_W-1:0]            o_delta
);

    localparam int SW = eeid_pkg::STAMP_W;
    localparam int PW = eeid_pkg::PROD_W;
    localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int GN = HISTORY - 1;
    localparam int GL = (GN > 1) ? $clog2(GN) : 0;
    localparam int GP = 1 << GL;
    localparam int GPW = GP * SW;

    // Stage 2
    eeid_pkg::t_beat              r_s2_beat;
    logic [GN*SW-1:0]             r_s2_gaps;
    // Stage 3
    eeid_pkg::t_beat              r_s3_beat;
    logic [SW-1:0]                r_s3_largest;
    logic [PW-1:0]                r_s3_prod;
    // Output register
    logic                         r_out_valid;
    logic [eeid_pkg::DELTA_W-1:0] r_out_delta;

    // Bypass of the last forwarded stamp written at the previous edge
    logic                         r_fb_valid;
    logic [LW-1:0]                r_fb_addr;
    logic [SW-1:0]                r_fb_data;
    logic [LINES-1:0]             r_bvld;

    logic [GPW-1:0]               gaps_pad;
    logic [SW-1:0]                tree [GP];
    logic [PW-1:0]                prod;
    logic [LW-1:0]                s3_addr;
    logic [SW-1:0]                rd_last;
    logic [SW-1:0]                last_fwd;
    logic [SW-1:0]                since;
    logic                         fwd;
    logic                         wr_en;
    logic [eeid_pkg::DELTA_W-1:0] n_delta;

    // Largest gap as a pairwise tree; unused leaves read as zero
    always_comb begin
        gaps_pad = GPW'(r_s2_gaps);
        for (int j = 0; j < GP; j++) begin
            tree[j] = gaps_pad[j*SW +: SW];
        end
        for (int l = 0; l < GL; l++) begin
            for (int j = 0; j < (GP >> (l + 1)); j++) begin
                tree[j] = (tree[2*j] > tree[2*j+1]) ? tree[2*j] : tree[2*j+1];
            end
        end
    end

    // Newest gap weighted by the ratio
    assign prod = r_s2_gaps[SW-1:0] * i_ratio;

    assign s3_addr = LW'(r_s3_beat.line);

    eeid_ram #(
        .WIDTH (SW),
        .DEPTH (LINES)
    ) u_last_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (s3_addr),
        .i_wr_data (r_s3_beat.ts),
        .i_rd_en   (i_en),
        .i_rd_addr (LW'(r_s2_beat.line)),
        .o_rd_data (rd_last)
    );

    // Forward test and result
    always_comb begin
        if (r_fb_valid && (r_fb_addr == s3_addr)) begin
            last_fwd = r_fb_data;
        end else if ((r_s3_beat.kind != eeid_pkg::KIND_RANGE) && r_bvld[s3_addr]) begin
            last_fwd = rd_last;
        end else begin
            last_fwd = '0;
        end
        since   = r_s3_beat.ts - last_fwd;
        fwd     = 1'b0;
        n_delta = '0;
        case (r_s3_beat.kind)
            eeid_pkg::KIND_RANGE: begin
                n_delta = eeid_pkg::DELTA_RANGE;
            end
            eeid_pkg::KIND_QUIET: begin
                n_delta = '0;
            end
            eeid_pkg::KIND_FIRST: begin
                fwd     = 1'b1;
                n_delta = eeid_pkg::clamp_delta(r_s3_largest);
            end
            eeid_pkg::KIND_TEST: begin
                if (r_s3_prod > PW'(r_s3_largest)) begin
                    fwd     = 1'b1;
                    n_delta = eeid_pkg::clamp_delta(since);
                end
            end
            default: begin
                n_delta = '0;
            end
        endcase
    end

    assign wr_en = i_en && r_s3_beat.valid && fwd;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_beat   <= '0;
            r_s3_beat   <= '0;
            r_out_valid <= 1'b0;
            r_fb_valid  <= 1'b0;
            r_bvld      <= '0;
        end else if (i_en) begin
            r_s2_beat   <= i_beat;
            r_s3_beat   <= r_s2_beat;
            r_out_valid <= r_s3_beat.valid;
            r_fb_valid  <= wr_en;
            if (wr_en) begin
                r_bvld[s3_addr] <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_gaps    <= i_gaps;
            r_s3_largest <= tree[0];
            r_s3_prod    <= prod;
            r_out_delta  <= n_delta;
            r_fb_addr    <= s3_addr;
            r_fb_data    <= r_s3_beat.ts;
        end
    end

    assign o_valid = r_out_valid;
    assign o_delta = r_out_delta;

endmodule

/* rtl/edge_event_interval_debouncer.sv */
// ----------------------------------------------------------------------------
// edge_event_interval_debouncer
// Per-line debouncer for falling-edge events with interval reporting.
// ----------------------------------------------------------------------------
// Takes one event beat per clock while the output is not stalled and returns
// exactly one delta_ms beat per event, in order; the result beat passes the
// history stage register, the decision stage registers and the output
// register. The rate of one beat per cycle is set by the two per-line RAMs:
// the history RAM (timestamps and fill count) is read at acceptance and
// written back from the history stage register, the last-forwarded RAM is
// read from the first decision stage and written back from the last; each has
// a one-entry bypass so back-to-back events on the same line see the updated
// entry. Per-line written flags make never-written entries read as zero, so
// the block is ready right after reset with no clearing pass. A stalled output
// stalls the whole pipeline. Write min_gap_ms and accept_ratio only while the block is idle.
// ----------------------------------------------------------------------------
module edge_event_interval_debouncer #(
    parameter int LINES   = eeid_pkg::LINES_DEF,
    parameter int HISTORY = eeid_pkg::HISTORY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Event stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [eeid_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [5:0] line_index, [53:6] event_ms
    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [eeid_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [30:0] delta_ms
    // Configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [eeid_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [eeid_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SW = eeid_pkg::STAMP_W;
    localparam int LN = eeid_pkg::LINE_W;

    logic [eeid_pkg::MIN_GAP_W-1:0] r_min_gap;
    logic [eeid_pkg::RATIO_W-1:0]   r_ratio;

    logic                           en;
    logic                           out_valid;
    logic [eeid_pkg::DELTA_W-1:0]   out_delta;
    eeid_pkg::t_beat                beat;
    logic [(HISTORY-1)*SW-1:0]      gaps;

    // Advance the pipeline unless the result register is held
    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap <= eeid_pkg::MIN_GAP_RESET;
            r_ratio   <= eeid_pkg::RATIO_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                eeid_pkg::REG_MIN_GAP: r_min_gap <= i_cfg_data;
                eeid_pkg::REG_RATIO:   r_ratio   <= i_cfg_data[eeid_pkg::RATIO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    eeid_hist #(
        .LINES   (LINES),
        .HISTORY (HISTORY)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (s_axis_tvalid),
        .i_line    (s_axis_tdata[LN-1:0]),
        .i_ts      (s_axis_tdata[LN+SW-1:LN]),
        .i_min_gap (r_min_gap),
        .o_beat    (beat),
        .o_gaps    (gaps)
    );

    eeid_decide #(
        .LINES   (LINES),
        .HISTORY (HISTORY)
    ) u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_beat  (beat),
        .i_gaps  (gaps),
        .i_ratio (r_ratio),
        .o_valid (out_valid),
        .o_delta (out_delta)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {1'b0, out_delta};

endmodule

/* rtl/eeid_checker.sv */
// ----------------------------------------------------------------------------
// eeid_checker
// Port-level checks for the edge event interval debouncer, bound to the top.
// ----------------------------------------------------------------------------
module eeid_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [eeid_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Keep the pad bit above delta_ms clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[eeid_pkg::OUT_TDATA_W-1] == 1'b0))
        else $error("result pad bit set");

    // Drop input ready only behind a stalled result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input ready low without output stall");

    // Start empty after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result beat right after reset");

endmodule

bind edge_event_interval_debouncer eeid_checker u_eeid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
